/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of the histogram core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define WMH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define WMH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
// Next-cycle implication that also holds across reset.
`define WMH_ASSERT_NXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/whm_pkg.sv */
// Package with types, constants and helpers of the weighted momentum histogram.
package whm_pkg;
    localparam int MAX_FIRST_BINS  = 64;
    localparam int MAX_SECOND_BINS = 64;
    localparam int ACC_WIDTH       = 48;
    localparam int STORE_DEPTH     = MAX_FIRST_BINS * MAX_SECOND_BINS;
    localparam int IDX_W           = 12;
    localparam int DIV_STEPS       = 7;

    localparam logic [1:0] MODE_ACC  = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_CLR  = 2'd2;

    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_READ    = 2'd3;

    localparam logic [2:0] REG_KIND  = 3'd0;
    localparam logic [2:0] REG_SCALE = 3'd1;
    localparam logic [2:0] REG_F_MIN = 3'd2;
    localparam logic [2:0] REG_F_MAX = 3'd3;
    localparam logic [2:0] REG_S_MIN = 3'd4;
    localparam logic [2:0] REG_S_MAX = 3'd5;
    localparam logic [2:0] REG_F_BIN = 3'd6;
    localparam logic [2:0] REG_S_BIN = 3'd7;

    typedef enum logic [1:0] {OP_ACC, OP_READ, OP_CLR, OP_SKIP} t_op;

    typedef struct packed {
        t_op              op;
        logic [1:0]       status;
        logic [IDX_W-1:0] idx;
        logic [31:0]      weight;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] scale;
        logic [31:0] first_min;
        logic [31:0] first_max;
        logic [31:0] second_min;
        logic [31:0] second_max;
        logic [6:0]  first_bins;
        logic [6:0]  second_bins;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    typedef struct packed {
        logic init_done;
    } t_back_stat;

    typedef struct packed {
        logic [1:0] c1;
        logic [1:0] c2;
        logic       two;
    } t_pick;

    typedef enum logic [2:0] {F_IDLE, F_MUL, F_CHK, F_DIV, F_IDX, F_PUSH} t_fstate;
    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_UPD} t_bstate;

    function automatic t_pick pick_components(input logic [3:0] kind);
        t_pick p;
        case (kind)
            4'd1:    p = '{c1: 2'd1, c2: 2'd0, two: 1'b0};
            4'd2:    p = '{c1: 2'd2, c2: 2'd0, two: 1'b0};
            4'd3:    p = '{c1: 2'd0, c2: 2'd1, two: 1'b1};
            4'd4:    p = '{c1: 2'd1, c2: 2'd0, two: 1'b1};
            4'd5:    p = '{c1: 2'd0, c2: 2'd2, two: 1'b1};
            4'd6:    p = '{c1: 2'd2, c2: 2'd0, two: 1'b1};
            4'd7:    p = '{c1: 2'd1, c2: 2'd2, two: 1'b1};
            4'd8:    p = '{c1: 2'd2, c2: 2'd1, two: 1'b1};
            default: p = '{c1: 2'd0, c2: 2'd0, two: 1'b0};
        endcase
        return p;
    endfunction

    function automatic logic [6:0] clamp_bins(input logic [6:0] n, input logic [6:0] lim);
        return (n > lim) ? lim : n;
    endfunction
endpackage

/* rtl/weighted_momentum_histogram_core.sv */
// Top level of the weighted momentum histogram: register port, front, queue and back end.
// Usage: sample and read words enter on the s_axis channel, one result word per input
// word leaves on the m_axis channel in input order. Registers are to be written over the
// APB-style port while the block is idle (not enforced by it); pready is always high.
// After reset the block sweeps the 4096-entry histogram store to zero, one entry per
// cycle, so s_axis_tready stays low until the sweep is done. An accumulate word takes
// one multiply, one range check and seven divide steps per axis in the front, one axis
// for 1D kinds and two for 2D kinds, then an index step; read, clear and zero-weight
// words, and a word that fails a range check, go straight to the queue. The front
// serial divider sets the rate. The back end reads the entry, then for a clear or add
// writes it back, and registers the result word; a skipped word is answered on its pop.
// The front accepts one word at a time; a two-entry queue lets it keep binning while
// the back end or the receiver stalls. A stalled result word holds its data until
// m_axis_tready is seen high; further words back up into the queue, then the front.
module weighted_momentum_histogram_core import whm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // mode[1:0], pot_x[33:2], pot_y[65:34], pot_z[97:66], weight[129:98],
    // read_bin[141:130], zero padding [143:142]
    input  logic [143:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status[1:0], bin_index[13:2], bin_value[61:14], zero padding [63:62]
    output logic [63:0]   m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    t_cfg             r_cfg;
    t_back_stat       back_stat;
    t_q_flags         qflags;
    t_cmd             f_cmd, q_cmd;
    logic             f_push, b_pop;
    logic [1:0]       o_status;
    logic [IDX_W-1:0] o_bin_index;
    logic [47:0]      o_bin_value;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind        <= 4'd0;
            r_cfg.scale       <= 32'd65536;
            r_cfg.first_min   <= '0;
            r_cfg.first_max   <= '0;
            r_cfg.second_min  <= '0;
            r_cfg.second_max  <= '0;
            r_cfg.first_bins  <= 7'd1;
            r_cfg.second_bins <= 7'd1;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_KIND:  r_cfg.kind        <= pwdata[3:0];
                REG_SCALE: r_cfg.scale       <= pwdata;
                REG_F_MIN: r_cfg.first_min   <= pwdata;
                REG_F_MAX: r_cfg.first_max   <= pwdata;
                REG_S_MIN: r_cfg.second_min  <= pwdata;
                REG_S_MAX: r_cfg.second_max  <= pwdata;
                REG_F_BIN: r_cfg.first_bins  <= pwdata[6:0];
                REG_S_BIN: r_cfg.second_bins <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_KIND:  prdata = {28'd0, r_cfg.kind};
            REG_SCALE: prdata = r_cfg.scale;
            REG_F_MIN: prdata = r_cfg.first_min;
            REG_F_MAX: prdata = r_cfg.first_max;
            REG_S_MIN: prdata = r_cfg.second_min;
            REG_S_MAX: prdata = r_cfg.second_max;
            REG_F_BIN: prdata = {25'd0, r_cfg.first_bins};
            REG_S_BIN: prdata = {25'd0, r_cfg.second_bins};
            default:   prdata = '0;
        endcase
    end

    whm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_back     (back_stat),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_mode     (s_axis_tdata[1:0]),
        .i_pot_x    (s_axis_tdata[33:2]),
        .i_pot_y    (s_axis_tdata[65:34]),
        .i_pot_z    (s_axis_tdata[97:66]),
        .i_weight   (s_axis_tdata[129:98]),
        .i_read_bin (s_axis_tdata[141:130]),
        .i_qflags   (qflags),
        .o_push     (f_push),
        .o_cmd      (f_cmd)
    );

    whm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (b_pop),
        .o_cmd   (q_cmd),
        .o_flags (qflags)
    );

    whm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_qflags    (qflags),
        .o_pop       (b_pop),
        .o_stat      (back_stat),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (o_status),
        .o_bin_index (o_bin_index),
        .o_bin_value (o_bin_value)
    );

    assign m_axis_tdata = {2'b00, o_bin_value, o_bin_index, o_status};
endmodule

/* rtl/whm_queue.sv */
// Two-entry command queue between the binning front and the store back end.
module whm_queue import whm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cmd     i_cmd,
    input  logic     i_pop,
    output t_cmd     o_cmd,
    output t_q_flags o_flags
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_push, n_pop;

    assign n_push = i_push && (r_cnt != 2'd2);
    assign n_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) r_wp <= ~r_wp;
            if (n_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(n_push) - 2'(n_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) r_mem[r_wp] <= i_cmd;
    end

    assign o_cmd         = r_mem[r_rp];
    assign o_flags.full  = (r_cnt == 2'd2);
    assign o_flags.empty = (r_cnt == 2'd0);
endmodule

/* rtl/whm_front.sv */
// Front end: accepts words, scales to momentum, bins each axis and queues a command.
module whm_front import whm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_back_stat  i_back,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_pot_x,
    input  logic [31:0] i_pot_y,
    input  logic [31:0] i_pot_z,
    input  logic [31:0] i_weight,
    input  logic [11:0] i_read_bin,
    input  t_q_flags    i_qflags,
    output logic        o_push,
    output t_cmd        o_cmd
);
    t_fstate            r_state, n_state;
    logic [31:0]        r_pot [3];
    logic               r_axis;
    t_pick              r_sel;
    logic signed [47:0] r_p;
    logic [39:0]        r_num, r_shd;
    logic [6:0]         r_q;
    logic [2:0]         r_cnt;
    logic [5:0]         r_b1, r_b2;
    t_cmd               r_cmd;

    logic               accept;
    logic [1:0]         comp;
    logic signed [63:0] prod;
    logic [6:0]         n1c, n2c, nax;
    logic signed [47:0] lo, hi, diff, span;
    logic               bad, ge, div_done;
    logic [6:0]         qf;
    logic [5:0]         bq;
    logic [12:0]        idx_sum;

    assign n1c    = clamp_bins(i_cfg.first_bins, 7'(MAX_FIRST_BINS));
    assign n2c    = clamp_bins(i_cfg.second_bins, 7'(MAX_SECOND_BINS));
    assign accept = i_valid && o_ready;

    always_comb begin
        comp = r_axis ? r_sel.c2 : r_sel.c1;
        prod = $signed(r_pot[comp]) * $signed(i_cfg.scale);
        lo   = r_axis ? 48'($signed(i_cfg.second_min)) : 48'($signed(i_cfg.first_min));
        hi   = r_axis ? 48'($signed(i_cfg.second_max)) : 48'($signed(i_cfg.first_max));
        nax  = r_axis ? n2c : n1c;
        diff = r_p - lo;
        span = hi - lo;
        bad  = !(hi > lo) || (nax == 7'd0) || (r_p < lo) || (r_p >= hi);
        ge   = (r_num >= r_shd);
        qf   = {r_q[5:0], ge};
        bq   = (qf >= nax) ? 6'(nax - 7'd1) : qf[5:0];
        div_done = (r_cnt == 3'(DIV_STEPS - 1));
        idx_sum  = 13'(r_b2) * 13'(n1c) + 13'(r_b1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = ((i_mode != MODE_ACC) || (i_weight == 32'd0)) ? F_PUSH : F_MUL;
                end
            end
            F_MUL:  n_state = F_CHK;
            F_CHK:  n_state = bad ? F_PUSH : F_DIV;
            F_DIV: begin
                if (div_done) n_state = (!r_axis && r_sel.two) ? F_MUL : F_IDX;
            end
            F_IDX:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_qflags.full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE) && i_back.init_done;
        o_push  = (r_state == F_PUSH) && !i_qflags.full;
        o_cmd   = r_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    r_pot[0] <= i_pot_x;
                    r_pot[1] <= i_pot_y;
                    r_pot[2] <= i_pot_z;
                    r_axis   <= 1'b0;
                    r_sel    <= pick_components(i_cfg.kind);
                    r_cmd.weight <= i_weight;
                    if (i_mode == MODE_CLR) begin
                        r_cmd.op     <= OP_CLR;
                        r_cmd.status <= ST_READ;
                        r_cmd.idx    <= i_read_bin;
                    end else if (i_mode != MODE_ACC) begin
                        r_cmd.op     <= OP_READ;
                        r_cmd.status <= ST_READ;
                        r_cmd.idx    <= i_read_bin;
                    end else begin
                        r_cmd.op     <= OP_SKIP;
                        r_cmd.status <= ST_ZERO;
                        r_cmd.idx    <= '0;
                    end
                end
            end
            F_MUL: r_p <= prod[63:16];
            F_CHK: begin
                if (bad) begin
                    r_cmd.op     <= OP_SKIP;
                    r_cmd.status <= ST_RANGE;
                    r_cmd.idx    <= '0;
                end
                r_num <= 40'(diff[32:0]) * 40'(nax);
                r_shd <= {1'b0, span[32:0], 6'b0};
                r_q   <= '0;
                r_cnt <= '0;
            end
            F_DIV: begin
                if (ge) r_num <= r_num - r_shd;
                r_shd <= r_shd >> 1;
                r_q   <= qf;
                r_cnt <= r_cnt + 3'd1;
                if (div_done) begin
                    if (!r_axis) begin
                        r_b1   <= bq;
                        r_b2   <= '0;
                        r_axis <= 1'b1;
                    end else begin
                        r_b2 <= bq;
                    end
                end
            end
            F_IDX: begin
                r_cmd.op     <= OP_ACC;
                r_cmd.status <= ST_COUNTED;
                r_cmd.idx    <= idx_sum[12] ? 12'(STORE_DEPTH - 1) : idx_sum[11:0];
            end
            default: ;
        endcase
    end
endmodule

/* rtl/whm_back.sv */
// Back end: clears the store after reset, runs read-modify-write and holds the result word.
module whm_back import whm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_q_flags          i_qflags,
    output logic              o_pop,
    output t_back_stat        o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [IDX_W-1:0]  o_bin_index,
    output logic [47:0]       o_bin_value
);
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

    logic [ACC_WIDTH-1:0] r_mem [STORE_DEPTH];
    logic [ACC_WIDTH-1:0] r_rdata;
    t_bstate              r_state, n_state;
    logic [IDX_W-1:0]     r_clr_addr;
    t_cmd                 r_cmd;
    logic                 r_ovalid;
    logic [1:0]           r_ostatus;
    logic [IDX_W-1:0]     r_oidx;
    logic [47:0]          r_oval;

    logic                 out_free, we;
    logic [IDX_W-1:0]     waddr;
    logic [ACC_WIDTH-1:0] wdata, newval;
    logic [ACC_WIDTH:0]   sum;

    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: if (r_clr_addr == IDX_W'(STORE_DEPTH - 1)) n_state = B_IDLE;
            B_IDLE:  if (o_pop && (i_cmd.op != OP_SKIP)) n_state = B_READ;
            B_READ:  n_state = B_UPD;
            B_UPD:   n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == B_IDLE) && !i_qflags.empty && out_free;
        o_stat.init_done = (r_state != B_CLEAR);
        sum    = {1'b0, r_rdata} + (ACC_WIDTH + 1)'(r_cmd.weight);
        newval = sum[ACC_WIDTH] ? ACC_MAX : sum[ACC_WIDTH-1:0];
        we     = 1'b0;
        waddr  = r_cmd.idx;
        wdata  = '0;
        if (r_state == B_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (r_state == B_UPD) begin
            we    = (r_cmd.op != OP_READ);
            wdata = (r_cmd.op == OP_ACC) ? newval : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[r_cmd.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (o_pop && (i_cmd.op == OP_SKIP)) begin
                r_ovalid <= 1'b1;
            end else if (r_state == B_UPD) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            if (i_cmd.op == OP_SKIP) begin
                r_ostatus <= i_cmd.status;
                r_oidx    <= '0;
                r_oval    <= '0;
            end
        end
        if (r_state == B_UPD) begin
            r_ostatus <= r_cmd.status;
            r_oidx    <= r_cmd.idx;
            r_oval    <= (r_cmd.op == OP_ACC) ? 48'(newval) : 48'(r_rdata);
        end
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_bin_index = r_oidx;
    assign o_bin_value = r_oval;
endmodule

/* rtl/whm_checker.sv */
// Port-level checker for the histogram core and its bind statement.
`include "assert_macros.svh"
module whm_checker import whm_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic         pready
);
    logic skipped;
    assign skipped = (m_axis_tdata[1:0] == ST_ZERO) || (m_axis_tdata[1:0] == ST_RANGE);

    `WMH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `WMH_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `WMH_ASSERT_IMP(a_skip_empty, i_clk, i_rst_n, m_axis_tvalid && skipped, m_axis_tdata[61:2] == 60'd0)
    `WMH_ASSERT_NXT_NR(a_reset_quiet, i_clk, !i_rst_n, !m_axis_tvalid && !s_axis_tready)
    `WMH_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind weighted_momentum_histogram_core whm_checker u_whm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
